// ===== rtl/core/char_lcd_bus_sequencer_macros.svh =====
// assertion macros for the character lcd bus sequencer
`ifndef CHAR_LCD_BUS_SEQUENCER_MACROS_SVH
`define CHAR_LCD_BUS_SEQUENCER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define CLS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cls check failed: same-cycle implication");
// next-cycle implication, checked out of reset
`define CLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cls check failed: next-cycle implication");
`else
`define CLS_ASSERT_NOW(lbl, ante, cons)
`define CLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/cls_pkg.sv =====
// types, codes and helpers shared by the lcd bus sequencer modules
`default_nettype none

package cls_pkg;

    // request function codes
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_CMD  = 2'd1;
    localparam logic [1:0] FUNC_DATA = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_SETUP_TICKS = 3'd0;
    localparam logic [2:0] CFG_PULSE_TICKS = 3'd1;
    localparam logic [2:0] CFG_HOLD_TICKS  = 3'd2;
    localparam logic [2:0] CFG_POLL_LIMIT  = 3'd3;

    // configuration reset values
    localparam logic [9:0]  SETUP_TICKS_RST = 10'd15;
    localparam logic [9:0]  PULSE_TICKS_RST = 10'd36;
    localparam logic [9:0]  HOLD_TICKS_RST  = 10'd22;
    localparam logic [15:0] POLL_LIMIT_RST  = 16'd1024;

    // busy flag position on the data lines
    localparam int BUSY_BIT = 7;

    // bus phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_SETUP = 4'b0010,
        PH_PULSE = 4'b0100,
        PH_HOLD  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] byte_value;
        logic [7:0] bus_in;
    } req_t;

    typedef struct packed {
        logic       en;
        logic       rs;
        logic       rw;
        logic [7:0] bus_out;
        logic       bus_drive;
        logic       ready_res;
        logic       accepted;
        logic       rejected;
        logic       timed_out;
    } res_t;

    typedef struct packed {
        logic [9:0]  setup_ticks;
        logic [9:0]  pulse_ticks;
        logic [9:0]  hold_ticks;
        logic [15:0] poll_limit;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [9:0]  tick_count;
        logic [15:0] polls_left;
        logic [7:0]  held_byte;
        logic        held_is_data;
        logic        busy_seen;
        logic        in_write;
    } state_t;

    // a zero length acts as one
    function automatic logic [9:0] min_one_len(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

    function automatic logic [15:0] min_one_polls(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cls_cfg.sv =====
// configuration registers for the lcd bus sequencer
`default_nettype none

module cls_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [2:0]   wr_index,
    input  wire logic [15:0]  wr_data,
    output cls_pkg::cfg_t     cfg
);

    cls_pkg::cfg_t cfg_reg;
    cls_pkg::cfg_t cfg_next;

    // decode the register write, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                cls_pkg::CFG_SETUP_TICKS: cfg_next.setup_ticks = wr_data[9:0];
                cls_pkg::CFG_PULSE_TICKS: cfg_next.pulse_ticks = wr_data[9:0];
                cls_pkg::CFG_HOLD_TICKS:  cfg_next.hold_ticks  = wr_data[9:0];
                cls_pkg::CFG_POLL_LIMIT:  cfg_next.poll_limit  = wr_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup_ticks <= cls_pkg::SETUP_TICKS_RST;
            cfg_reg.pulse_ticks <= cls_pkg::PULSE_TICKS_RST;
            cfg_reg.hold_ticks  <= cls_pkg::HOLD_TICKS_RST;
            cfg_reg.poll_limit  <= cls_pkg::POLL_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cls_step.sv =====
// one tick of bus sequencing: next state and pin outputs from state and request
`default_nettype none

module cls_step (
    input  wire cls_pkg::cfg_t   cfg,
    input  wire cls_pkg::state_t state,
    input  wire cls_pkg::req_t   req,
    output cls_pkg::state_t      state_next,
    output cls_pkg::res_t        res
);

    always_comb
    begin
        logic            request;
        logic            active;
        logic [9:0]      tick_inc;
        logic [9:0]      len;
        cls_pkg::state_t cur;

        request  = (req.func == cls_pkg::FUNC_CMD) || (req.func == cls_pkg::FUNC_DATA);
        active   = 1'b1;
        cur      = state;
        res      = '0;
        tick_inc = 10'd0;
        len      = 10'd1;

        // idle handling: take a new request; in a busy phase, flag a request as rejected
        case (state.phase)
            cls_pkg::PH_SETUP,
            cls_pkg::PH_PULSE,
            cls_pkg::PH_HOLD:
            begin
                res.rejected = request;
            end
            default:
            begin
                res.ready_res = 1'b1;
                cur.phase     = cls_pkg::PH_IDLE;
                if (request)
                begin
                    res.accepted     = 1'b1;
                    cur.held_byte    = req.byte_value;
                    cur.held_is_data = (req.func == cls_pkg::FUNC_DATA);
                    cur.busy_seen    = 1'b1;
                    cur.in_write     = 1'b0;
                    cur.polls_left   = cls_pkg::min_one_polls(cfg.poll_limit);
                    cur.phase        = cls_pkg::PH_SETUP;
                    cur.tick_count   = 10'd0;
                end
                else
                begin
                    active = 1'b0;
                end
            end
        endcase

        state_next = cur;

        if (active)
        begin
            // pin levels for this tick
            res.en = (cur.phase == cls_pkg::PH_PULSE);
            if (cur.in_write)
            begin
                res.rs        = cur.held_is_data;
                res.rw        = 1'b0;
                res.bus_out   = cur.held_byte;
                res.bus_drive = 1'b1;
            end
            else
            begin
                res.rw = 1'b1;
            end

            // length of the current phase
            case (cur.phase)
                cls_pkg::PH_SETUP: len = cls_pkg::min_one_len(cfg.setup_ticks);
                cls_pkg::PH_PULSE: len = cls_pkg::min_one_len(cfg.pulse_ticks);
                default:           len = cls_pkg::min_one_len(cfg.hold_ticks);
            endcase

            // advance the tick counter and step the phase at its end
            tick_inc              = cur.tick_count + 10'd1;
            state_next.tick_count = tick_inc;
            if (tick_inc >= len)
            begin
                state_next.tick_count = 10'd0;
                case (cur.phase)
                    cls_pkg::PH_SETUP:
                    begin
                        state_next.phase = cls_pkg::PH_PULSE;
                    end
                    cls_pkg::PH_PULSE:
                    begin
                        if (!cur.in_write)
                        begin
                            state_next.busy_seen = req.bus_in[cls_pkg::BUSY_BIT];
                        end
                        state_next.phase = cls_pkg::PH_HOLD;
                    end
                    default:
                    begin
                        if (cur.in_write)
                        begin
                            state_next.in_write = 1'b0;
                            state_next.phase    = cls_pkg::PH_IDLE;
                        end
                        else
                        begin
                            state_next.polls_left = cur.polls_left - 16'd1;
                            state_next.phase      = cls_pkg::PH_SETUP;
                            if (!(cur.busy_seen && (state_next.polls_left != 16'd0)))
                            begin
                                // polling over, write goes ahead even on timeout
                                res.timed_out       = cur.busy_seen;
                                state_next.in_write = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/char_lcd_bus_sequencer.sv =====
// top level of the character lcd bus sequencer
//
//  channel | signals                          | direction | moves
//  --------+----------------------------------+-----------+---------------------------
//  req     | req_valid, req_ready, req        | in        | one bus tick with request
//  res     | res_valid, res_ready, res        | out       | pin levels and flags
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in        | timing and poll limit write
//          | cfg_data                         |           |
//
// one request is taken every cycle while req_ready is high; its result is registered
// in the output register. the path is a single pass through the step logic, bounded by the
// 10-bit tick compare and 16-bit poll decrement.
// reset puts the bus idle with default timing; the config port is always ready.
// a stalled result blocks new requests only when the output register is full
// and not being drained in the same cycle.
`default_nettype none

`include "char_lcd_bus_sequencer_macros.svh"

module char_lcd_bus_sequencer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_ready,
    input  wire cls_pkg::req_t req,
    output      logic          res_valid,
    input  wire logic          res_ready,
    output cls_pkg::res_t      res,
    input  wire logic          cfg_valid,
    output      logic          cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);

    cls_pkg::cfg_t   cfg;
    cls_pkg::state_t state_reg;
    cls_pkg::state_t state_next;
    cls_pkg::res_t   res_reg;
    cls_pkg::res_t   res_next;
    logic            res_valid_reg;
    logic            req_fire;
    logic            polling;

    // config registers
    assign cfg_ready = 1'b1;

    cls_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // per-tick step logic
    cls_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .req        (req),
        .state_next (state_next),
        .res        (res_next)
    );

    // request handshake against the output register
    assign req_ready = !res_valid_reg || res_ready;
    assign req_fire  = req_valid && req_ready;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= cls_pkg::PH_IDLE;
            state_reg.tick_count   <= 10'd0;
            state_reg.polls_left   <= 16'd0;
            state_reg.held_byte    <= 8'd0;
            state_reg.held_is_data <= 1'b0;
            state_reg.busy_seen    <= 1'b1;
            state_reg.in_write     <= 1'b0;
        end
        else if (req_fire)
        begin
            state_reg <= state_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // busy polling in progress
    assign polling = (state_reg.phase != cls_pkg::PH_IDLE) && !state_reg.in_write;

    // checks
    `CLS_ASSERT_NOW(a_accept_when_ready, res_valid_reg && res_reg.accepted, res_reg.ready_res)
    `CLS_ASSERT_NOW(a_timeout_in_poll, res_valid_reg && res_reg.timed_out, res_reg.rw && !res_reg.bus_drive)
    `CLS_ASSERT_NOW(a_polls_remain, polling, state_reg.polls_left != 16'd0)
    `CLS_ASSERT_NEXT(a_start_leaves_idle, req_fire && res_next.accepted, state_reg.phase != cls_pkg::PH_IDLE)

endmodule

`default_nettype wire

// ===== dv/char_lcd_bus_sequencer_test.sv =====
// self-checking testbench for the character lcd bus sequencer
`timescale 1ns / 100ps

module char_lcd_bus_sequencer_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SEG_ITEMS      = 380;
    localparam int MAX_SHOWN      = 10;

    // spare function code, behaves as a plain tick
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // pin levels that can be read straight off the timing rules
    localparam cls_pkg::res_t IDLE_PINS = '{en: 1'b0, rs: 1'b0, rw: 1'b0, bus_out: 8'h00,
        bus_drive: 1'b0, ready_res: 1'b1, accepted: 1'b0, rejected: 1'b0,
        timed_out: 1'b0};
    localparam cls_pkg::res_t TAKEN_PINS = '{en: 1'b0, rs: 1'b0, rw: 1'b1, bus_out: 8'h00,
        bus_drive: 1'b0, ready_res: 1'b1, accepted: 1'b1, rejected: 1'b0,
        timed_out: 1'b0};
    localparam cls_pkg::res_t DROPPED_PINS = '{en: 1'b0, rs: 1'b0, rw: 1'b1, bus_out: 8'h00,
        bus_drive: 1'b0, ready_res: 1'b0, accepted: 1'b0, rejected: 1'b1,
        timed_out: 1'b0};

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t     kind;
        cls_pkg::req_t item;
        bit            pinned;
        cls_pkg::res_t pins;
        logic [2:0]    reg_idx;
        logic [15:0]   reg_val;
    } row_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    cls_pkg::req_t req;
    logic          res_valid;
    logic          res_ready;
    cls_pkg::res_t res;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [2:0]    cfg_index;
    logic [15:0]   cfg_data;

    // predictor copy of the bus state and timing registers
    cls_pkg::phase_t bus_phase;
    logic [9:0]      phase_ticks;
    logic [15:0]     polls_remaining;
    logic [7:0]      out_byte;
    logic            out_is_data;
    logic            lcd_busy;
    logic            writing;
    logic [9:0]      setup_len;
    logic [9:0]      pulse_len;
    logic [9:0]      hold_len;
    logic [15:0]     poll_max;

    cls_pkg::res_t pins_due[$];
    row_t          dir_rows[$];
    cls_pkg::res_t step_pins;
    cls_pkg::res_t want;
    string         bad;

    bit            pinned_next;
    cls_pkg::res_t pinned_pins;
    int            send_idle_pct;
    int            recv_idle_pct;

    int    items_taken;
    int    n_checked;
    int    n_requests;
    int    n_dropped;
    int    n_timeouts;
    int    n_reg_writes;
    int    n_errors;
    int    n_shown;
    int    quiet_cycles;

    char_lcd_bus_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one bus tick: pin levels for this tick, then advance the phase timer
    function automatic cls_pkg::res_t predict_pins(input cls_pkg::req_t item);
        cls_pkg::res_t pins;
        logic          asking;
        logic [9:0]    span;
        pins   = '0;
        asking = (item.func == cls_pkg::FUNC_CMD) || (item.func == cls_pkg::FUNC_DATA);
        if (bus_phase == cls_pkg::PH_IDLE)
        begin
            pins.ready_res = 1'b1;
            if (!asking)
                return pins;
            pins.accepted   = 1'b1;
            out_byte        = item.byte_value;
            out_is_data     = (item.func == cls_pkg::FUNC_DATA);
            lcd_busy        = 1'b1;
            writing         = 1'b0;
            polls_remaining = (poll_max == 16'd0) ? 16'd1 : poll_max;
            bus_phase       = cls_pkg::PH_SETUP;
            phase_ticks     = 10'd0;
        end
        else if (asking)
            pins.rejected = 1'b1;

        pins.en = (bus_phase == cls_pkg::PH_PULSE);
        if (writing)
        begin
            pins.rs        = out_is_data;
            pins.rw        = 1'b0;
            pins.bus_out   = out_byte;
            pins.bus_drive = 1'b1;
        end
        else
            pins.rw = 1'b1;

        // phase timer, zero length counts as one
        case (bus_phase)
            cls_pkg::PH_SETUP: span = setup_len;
            cls_pkg::PH_PULSE: span = pulse_len;
            default:           span = hold_len;
        endcase
        if (span == 10'd0)
            span = 10'd1;
        phase_ticks = phase_ticks + 10'd1;
        if (phase_ticks >= span)
        begin
            phase_ticks = 10'd0;
            case (bus_phase)
                cls_pkg::PH_SETUP: bus_phase = cls_pkg::PH_PULSE;
                cls_pkg::PH_PULSE:
                begin
                    if (!writing)
                        lcd_busy = item.bus_in[cls_pkg::BUSY_BIT];
                    bus_phase = cls_pkg::PH_HOLD;
                end
                default:
                begin
                    if (writing)
                    begin
                        writing   = 1'b0;
                        bus_phase = cls_pkg::PH_IDLE;
                    end
                    else
                    begin
                        polls_remaining = polls_remaining - 16'd1;
                        if (!(lcd_busy && polls_remaining != 16'd0))
                        begin
                            pins.timed_out = lcd_busy;
                            writing        = 1'b1;
                        end
                        bus_phase = cls_pkg::PH_SETUP;
                    end
                end
            endcase
        end
        return pins;
    endfunction

    function automatic string pins_text(input cls_pkg::res_t p);
        return $sformatf("en=%0b rs=%0b rw=%0b out=%02h drv=%0b rdy=%0b acc=%0b rej=%0b tmo=%0b",
            p.en, p.rs, p.rw, p.bus_out, p.bus_drive, p.ready_res, p.accepted,
            p.rejected, p.timed_out);
    endfunction

    // receiver stalls
    always @(negedge clk)
        res_ready <= ($urandom_range(99) >= recv_idle_pct);

    // monitor: predictor update, result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // register writes land in the predictor copy
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cls_pkg::CFG_SETUP_TICKS: setup_len = cfg_data[9:0];
                    cls_pkg::CFG_PULSE_TICKS: pulse_len = cfg_data[9:0];
                    cls_pkg::CFG_HOLD_TICKS:  hold_len  = cfg_data[9:0];
                    cls_pkg::CFG_POLL_LIMIT:  poll_max  = cfg_data;
                    default: ;
                endcase
                n_reg_writes++;
            end

            // each accepted request gives one pin result
            if (req_valid && req_ready)
            begin
                step_pins = predict_pins(req);
                pins_due.push_back(pinned_next ? pinned_pins : step_pins);
                if (step_pins.accepted)
                    n_requests++;
                if (step_pins.rejected)
                    n_dropped++;
                if (step_pins.timed_out)
                    n_timeouts++;
                items_taken++;
            end

            // compare against the oldest expectation
            if (res_valid && res_ready)
            begin
                if (pins_due.size() == 0)
                begin
                    n_errors++;
                    if (n_shown < MAX_SHOWN)
                        $display("unexpected result: %s", pins_text(res));
                    n_shown++;
                end
                else
                begin
                    want = pins_due.pop_front();
                    bad  = "";
                    if (res.en !== want.en)               bad = {bad, " en"};
                    if (res.rs !== want.rs)               bad = {bad, " rs"};
                    if (res.rw !== want.rw)               bad = {bad, " rw"};
                    if (res.bus_out !== want.bus_out)     bad = {bad, " bus_out"};
                    if (res.bus_drive !== want.bus_drive) bad = {bad, " bus_drive"};
                    if (res.ready_res !== want.ready_res) bad = {bad, " ready_res"};
                    if (res.accepted !== want.accepted)   bad = {bad, " accepted"};
                    if (res.rejected !== want.rejected)   bad = {bad, " rejected"};
                    if (res.timed_out !== want.timed_out) bad = {bad, " timed_out"};
                    if (bad != "")
                    begin
                        n_errors++;
                        if (n_shown < MAX_SHOWN)
                        begin
                            $display("mismatch at result %0d on%s", n_checked, bad);
                            $display("  expected %s", pins_text(want));
                            $display("  actual   %s", pins_text(res));
                        end
                        n_shown++;
                    end
                    n_checked++;
                end
            end

            // watchdog on handshake activity
            if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no handshake for %0d cycles", quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // send one bus tick, holding valid until it is taken
    task automatic push_tick(input cls_pkg::req_t item, input bit pinned,
                             input cls_pkg::res_t pins);
        int target;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        req         <= item;
        pinned_next = pinned;
        pinned_pins = pins;
        target      = items_taken + 1;
        wait (items_taken == target);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // run the bus back to idle with plain ticks, then let results drain
    task automatic settle_bus(input int busy_pct);
        cls_pkg::req_t item;
        while (bus_phase != cls_pkg::PH_IDLE)
        begin
            item.func                      = cls_pkg::FUNC_TICK;
            item.byte_value                = 8'($urandom);
            item.bus_in                    = 8'($urandom);
            item.bus_in[cls_pkg::BUSY_BIT] = ($urandom_range(99) < busy_pct);
            push_tick(item, 1'b0, '0);
        end
        @(negedge clk);
        req_valid <= 1'b0;
        while (pins_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void add_item(input logic [1:0] f, input logic [7:0] b,
                                     input logic [7:0] bus, input bit pinned = 1'b0,
                                     input cls_pkg::res_t pins = '0);
        row_t r;
        r.kind            = ROW_ITEM;
        r.item.func       = f;
        r.item.byte_value = b;
        r.item.bus_in     = bus;
        r.pinned          = pinned;
        r.pins            = pins;
        r.reg_idx         = '0;
        r.reg_val         = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_reg(input logic [2:0] idx, input logic [15:0] val);
        row_t r;
        r.kind    = ROW_REG;
        r.item    = '0;
        r.pinned  = 1'b0;
        r.pins    = '0;
        r.reg_idx = idx;
        r.reg_val = val;
        dir_rows.push_back(r);
    endfunction

    // stimulus
    initial
    begin
        cls_pkg::req_t item;
        int            seg;
        int            seg_items;
        int            busy_pct;
        int            roll;
        bit            retune;
        logic [15:0]   junk;
        logic [9:0]    lens[3];
        logic [15:0]   polls;

        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        res_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pinned_next   = 1'b0;
        pinned_pins   = '0;
        send_idle_pct = 25;
        recv_idle_pct = 63;

        bus_phase       = cls_pkg::PH_IDLE;
        phase_ticks     = '0;
        polls_remaining = '0;
        out_byte        = '0;
        out_is_data     = 1'b0;
        lcd_busy        = 1'b1;
        writing         = 1'b0;
        setup_len       = cls_pkg::SETUP_TICKS_RST;
        pulse_len       = cls_pkg::PULSE_TICKS_RST;
        hold_len        = cls_pkg::HOLD_TICKS_RST;
        poll_max        = cls_pkg::POLL_LIMIT_RST;

        items_taken  = 0;
        n_checked    = 0;
        n_requests   = 0;
        n_dropped    = 0;
        n_timeouts   = 0;
        n_reg_writes = 0;
        n_errors     = 0;
        n_shown      = 0;
        quiet_cycles = 0;

        // after reset, default timing: idle ticks, spare code, accept, drops
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b1, IDLE_PINS);
        add_item(FUNC_SPARE,         8'hFF, 8'hFF, 1'b1, IDLE_PINS);
        add_item(cls_pkg::FUNC_CMD,  8'hFF, 8'hFF, 1'b1, TAKEN_PINS);
        add_item(cls_pkg::FUNC_DATA, 8'h00, 8'h00, 1'b1, DROPPED_PINS);
        add_item(cls_pkg::FUNC_CMD,  8'h55, 8'h80, 1'b1, DROPPED_PINS);
        // zero lengths and zero poll limit act as one, busy lcd times out
        add_reg(cls_pkg::CFG_SETUP_TICKS, 16'h0000);
        add_reg(cls_pkg::CFG_PULSE_TICKS, 16'h0001);
        add_reg(cls_pkg::CFG_HOLD_TICKS,  16'h0000);
        add_reg(cls_pkg::CFG_POLL_LIMIT,  16'h0000);
        add_item(cls_pkg::FUNC_DATA, 8'hA5, 8'h80);
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'hFF);
        add_item(cls_pkg::FUNC_TICK, 8'hFF, 8'hFF);
        add_item(cls_pkg::FUNC_CMD,  8'h3C, 8'h00);
        add_item(FUNC_SPARE,         8'h00, 8'h00);
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'h00);
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'h00);
        // busy once, then ready on the second poll
        add_reg(cls_pkg::CFG_POLL_LIMIT,  16'd3);
        add_reg(cls_pkg::CFG_SETUP_TICKS, 16'd2);
        add_item(cls_pkg::FUNC_CMD,  8'h00, 8'hFF);
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'hFF);
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'hFF);
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'h00);
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'h00);
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'h00);
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'h7F);
        add_item(cls_pkg::FUNC_TICK, 8'h00, 8'hFF);
        // upper data bits masked off, widest poll limit
        add_reg(cls_pkg::CFG_SETUP_TICKS, 16'hFC02);
        add_reg(cls_pkg::CFG_PULSE_TICKS, 16'hFC03);
        add_reg(cls_pkg::CFG_HOLD_TICKS,  16'hFC01);
        add_reg(cls_pkg::CFG_POLL_LIMIT,  16'hFFFF);
        add_item(cls_pkg::FUNC_DATA, 8'hFF, 8'h00);

        // reset, released on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                settle_bus(0);
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
                push_tick(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].pins);
        end

        // random transactions in three idling segments
        for (seg = 0; seg < 3; seg++)
        begin
            case (seg)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            seg_items = 0;
            retune    = 1'b1;
            while (seg_items < SEG_ITEMS)
            begin
                // new timing, written only with the bus idle
                if (retune)
                begin
                    settle_bus(0);
                    if ($urandom_range(0, 11) == 0)
                    begin
                        foreach (lens[k])
                            lens[k] = 10'($urandom_range(5, 30));
                        polls = 16'($urandom_range(0, 1));
                    end
                    else
                    begin
                        foreach (lens[k])
                            lens[k] = 10'($urandom_range(0, 4));
                        polls = 16'($urandom_range(0, 6));
                    end
                    junk = 16'($urandom);
                    write_reg(cls_pkg::CFG_SETUP_TICKS,
                        {($urandom_range(0, 2) == 0) ? junk[15:10] : 6'd0, lens[0]});
                    junk = 16'($urandom);
                    write_reg(cls_pkg::CFG_PULSE_TICKS,
                        {($urandom_range(0, 2) == 0) ? junk[15:10] : 6'd0, lens[1]});
                    junk = 16'($urandom);
                    write_reg(cls_pkg::CFG_HOLD_TICKS,
                        {($urandom_range(0, 2) == 0) ? junk[15:10] : 6'd0, lens[2]});
                    write_reg(cls_pkg::CFG_POLL_LIMIT, polls);
                end
                retune = ($urandom_range(0, 5) == 0);

                // a few idle ticks before the request
                repeat ($urandom_range(0, 2))
                begin
                    item.func       = ($urandom_range(0, 3) == 0) ? FUNC_SPARE
                                                                  : cls_pkg::FUNC_TICK;
                    item.byte_value = 8'($urandom);
                    item.bus_in     = 8'($urandom);
                    push_tick(item, 1'b0, '0);
                end

                // how often the lcd reads busy during this write
                case ($urandom_range(0, 3))
                    0:       busy_pct = 0;
                    1:       busy_pct = 35;
                    2:       busy_pct = 75;
                    default: busy_pct = 100;
                endcase

                item.func       = $urandom_range(0, 1) ? cls_pkg::FUNC_DATA : cls_pkg::FUNC_CMD;
                item.byte_value = 8'($urandom);
                item.bus_in     = 8'($urandom);
                push_tick(item, 1'b0, '0);
                seg_items++;

                // polls and write, with dropped requests as noise
                while (bus_phase != cls_pkg::PH_IDLE)
                begin
                    roll = $urandom_range(99);
                    if (roll < 8)
                        item.func = $urandom_range(0, 1) ? cls_pkg::FUNC_DATA
                                                         : cls_pkg::FUNC_CMD;
                    else if (roll < 12)
                        item.func = FUNC_SPARE;
                    else
                        item.func = cls_pkg::FUNC_TICK;
                    item.byte_value                = 8'($urandom);
                    item.bus_in                    = 8'($urandom);
                    item.bus_in[cls_pkg::BUSY_BIT] = ($urandom_range(99) < busy_pct);
                    push_tick(item, 1'b0, '0);
                    seg_items++;
                end
            end
        end

        // drain and report
        settle_bus(0);
        $display("run covered %0d bus ticks, %0d results checked, %0d register writes",
            items_taken, n_checked, n_reg_writes);
        $display("%0d writes started, %0d requests dropped while busy, %0d poll timeouts",
            n_requests, n_dropped, n_timeouts);
        if (n_errors == 0 && pins_due.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d failing results, %0d still expected", n_errors, pins_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
